// ===== rtl/core/vnz_pkg.sv =====
// Shared constants, types and the blend function for the 2D value noise pipeline.
package vnz_pkg;

  localparam int unsigned NUM_STAGES = 5;

  localparam logic [31:0] HASH_MUL_X   = 32'h9E3779B9;
  localparam logic [31:0] HASH_MUL_Y   = 32'h85EBCA6B;
  localparam logic [31:0] HASH_MUL_MIX = 32'hC2B2AE35;
  localparam logic [9:0]  EASE_BASE    = 10'd765;

  // per-stage load enables
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
    logic s5;
  } stage_en_t;

  // a + floor((b - a) * w / 256); the result always lies between a and b
  function automatic logic [7:0] lerp8(logic [7:0] a, logic [7:0] b, logic [7:0] w);
    logic signed [8:0]  diff;
    logic signed [8:0]  ws;
    logic signed [17:0] prod;
    logic signed [9:0]  sum;
    diff = $signed({1'b0, b}) - $signed({1'b0, a});
    ws   = $signed({1'b0, w});
    prod = diff * ws;
    sum  = $signed({2'b00, a}) + prod[17:8];
    return sum[7:0];
  endfunction

endpackage

// ===== rtl/core/vnz_hash.sv =====
// Three-stage corner hash: multiply-add, xor-shift, multiply, final xor-shift.
module vnz_hash
  import vnz_pkg::*;
(
  input  logic      clk_i,
  input  stage_en_t en_i,
  input  logic [7:0] cell_x_i,
  input  logic [7:0] cell_y_i,
  output logic [7:0] hash_o
);

  logic [31:0] mul_x_d, mul_x_q;
  logic [31:0] mul_y_d, mul_y_q;
  logic [31:0] sum;
  logic [31:0] mix_d, mix_q;
  logic [31:0] prod;
  logic [23:0] prod_d, prod_q;

  assign mul_x_d = {24'd0, cell_x_i} * HASH_MUL_X;
  assign mul_y_d = {24'd0, cell_y_i} * HASH_MUL_Y;
  assign sum     = mul_x_q + mul_y_q;
  assign mix_d   = sum ^ (sum >> 13);
  assign prod    = mix_q * HASH_MUL_MIX;
  // only the low byte survives, so bits 23:16 are all the final shift needs
  assign prod_d  = prod[23:0];
  assign hash_o  = prod_q[7:0] ^ prod_q[23:16];

  always_ff @(posedge clk_i) begin
    if (en_i.s1) begin
      mul_x_q <= mul_x_d;
      mul_y_q <= mul_y_d;
    end
    if (en_i.s2) begin
      mix_q <= mix_d;
    end
    if (en_i.s3) begin
      prod_q <= prod_d;
    end
  end

endmodule

// ===== rtl/core/vnz_ease.sv =====
// Three-stage cubic ease curve of an 8-bit fraction.
module vnz_ease
  import vnz_pkg::*;
(
  input  logic      clk_i,
  input  stage_en_t en_i,
  input  logic [7:0] frac_i,
  output logic [7:0] eased_o
);

  logic [7:0]  frac_q;
  logic [15:0] sq_d, sq_q;
  logic [9:0]  coef;
  logic [25:0] cube;
  logic [7:0]  eased_d, eased_q;
  logic [7:0]  eased_dly_q;

  assign sq_d    = {8'd0, frac_i} * {8'd0, frac_i};
  assign coef    = EASE_BASE - {1'b0, frac_q, 1'b0};
  assign cube    = {10'd0, sq_q} * {16'd0, coef};
  assign eased_d = cube[23:16];
  assign eased_o = eased_dly_q;

  always_ff @(posedge clk_i) begin
    if (en_i.s1) begin
      frac_q <= frac_i;
      sq_q   <= sq_d;
    end
    if (en_i.s2) begin
      eased_q <= eased_d;
    end
    // delay to line up with the hash
    if (en_i.s3) begin
      eased_dly_q <= eased_q;
    end
  end

endmodule

// ===== rtl/core/vnz_blend.sv =====
// Two-stage bilinear blend: along x for both rows, then along y.
module vnz_blend
  import vnz_pkg::*;
(
  input  logic      clk_i,
  input  stage_en_t en_i,
  input  logic [7:0] h00_i,
  input  logic [7:0] h10_i,
  input  logic [7:0] h01_i,
  input  logic [7:0] h11_i,
  input  logic [7:0] wx_i,
  input  logic [7:0] wy_i,
  output logic [7:0] noise_o
);

  logic [7:0] row0_q, row1_q, wy_q;
  logic [7:0] noise_q;

  assign noise_o = noise_q;

  always_ff @(posedge clk_i) begin
    if (en_i.s4) begin
      row0_q <= lerp8(h00_i, h10_i, wx_i);
      row1_q <= lerp8(h01_i, h11_i, wx_i);
      wy_q   <= wy_i;
    end
    if (en_i.s5) begin
      noise_q <= lerp8(row0_q, row1_q, wy_q);
    end
  end

endmodule

// ===== rtl/core/value_noise_2d_8bit.sv =====
// 2D value noise, 8-bit: five-stage pipeline from coordinates to noise value.
//
// Input channel: coord_x_i and coord_y_i with valid_i / ready_o. Each
// coordinate's high byte selects the lattice cell, the low byte is the
// fraction. Output channel: noise_value_o with valid_o / ready_i. A word
// moves when valid and ready are both high at a rising clock edge.
//
// valid_o rises once an accepted input word has reached the last of the
// five register stages. Throughput is one word per cycle, set by those
// stages (hash multiplies and ease square, hash add and xor-shift with
// ease cube, hash mix multiply, x blend, y blend), each of which loads a
// new word every cycle while it can pass its contents on.
//
// When the receiver stalls, words stay in their stages and the empty
// stages ahead of the stall still fill, so ready_o drops only once all
// five stages hold a word. The output word holds until it is taken.
// Reset (rst_ni low, asynchronous) empties the pipeline; no other state.
module value_noise_2d_8bit
  import vnz_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        ready_o,
  input  logic [15:0] coord_x_i,
  input  logic [15:0] coord_y_i,
  output logic        valid_o,
  input  logic        ready_i,
  output logic [7:0]  noise_value_o
);

  logic [NUM_STAGES-1:0] valid_q, valid_d;
  logic [NUM_STAGES-1:0] stage_rdy;
  stage_en_t             en;

  logic [7:0] cell_x, cell_y, cell_xn, cell_yn;
  logic [7:0] h00, h10, h01, h11;
  logic [7:0] wx, wy;

  // a stage can load when it is empty or its word moves on this cycle
  always_comb begin
    stage_rdy[NUM_STAGES-1] = !valid_q[NUM_STAGES-1] || ready_i;
    for (int k = NUM_STAGES - 2; k >= 0; k--) begin
      stage_rdy[k] = !valid_q[k] || stage_rdy[k+1];
    end
  end

  assign en.s1 = stage_rdy[0];
  assign en.s2 = stage_rdy[1];
  assign en.s3 = stage_rdy[2];
  assign en.s4 = stage_rdy[3];
  assign en.s5 = stage_rdy[4];

  always_comb begin
    valid_d = valid_q;
    if (stage_rdy[0]) begin
      valid_d[0] = valid_i;
    end
    for (int k = 1; k < NUM_STAGES; k++) begin
      if (stage_rdy[k]) begin
        valid_d[k] = valid_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign ready_o = stage_rdy[0];
  assign valid_o = valid_q[NUM_STAGES-1];

  assign cell_x  = coord_x_i[15:8];
  assign cell_y  = coord_y_i[15:8];
  assign cell_xn = cell_x + 8'd1;
  assign cell_yn = cell_y + 8'd1;

  vnz_hash u_hash00 (.clk_i, .en_i(en), .cell_x_i(cell_x),  .cell_y_i(cell_y),  .hash_o(h00));
  vnz_hash u_hash10 (.clk_i, .en_i(en), .cell_x_i(cell_xn), .cell_y_i(cell_y),  .hash_o(h10));
  vnz_hash u_hash01 (.clk_i, .en_i(en), .cell_x_i(cell_x),  .cell_y_i(cell_yn), .hash_o(h01));
  vnz_hash u_hash11 (.clk_i, .en_i(en), .cell_x_i(cell_xn), .cell_y_i(cell_yn), .hash_o(h11));

  vnz_ease u_ease_x (.clk_i, .en_i(en), .frac_i(coord_x_i[7:0]), .eased_o(wx));
  vnz_ease u_ease_y (.clk_i, .en_i(en), .frac_i(coord_y_i[7:0]), .eased_o(wy));

  vnz_blend u_blend (
    .clk_i,
    .en_i   (en),
    .h00_i  (h00),
    .h10_i  (h10),
    .h01_i  (h01),
    .h11_i  (h11),
    .wx_i   (wx),
    .wy_i   (wy),
    .noise_o(noise_value_o)
  );

  // an empty output stage lets the whole pipeline take a word
  a_empty_out_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !valid_q[NUM_STAGES-1] |-> ready_o)
    else $error("input blocked while output stage is empty");

  // a taken output frees the input side in the same cycle
  a_ready_chain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ready_i |-> ready_o)
    else $error("ready_i high but ready_o low");

  // back-pressure reaches the input only when every stage is full
  a_full_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !ready_o |-> (&valid_q))
    else $error("ready_o low with a bubble in the pipeline");

endmodule

// ===== bench/tb_top.sv =====
// Self-checking testbench for the 2D value noise pipeline: directed, random and stall tests.
module tb_top;

  localparam int unsigned  CYCLE_LIMIT = 200000;
  localparam int unsigned  DRAIN_CYCLES = 20;
  localparam logic [31:0]  MUL_X   = 32'h9E3779B9;
  localparam logic [31:0]  MUL_Y   = 32'h85EBCA6B;
  localparam logic [31:0]  MUL_MIX = 32'hC2B2AE35;
  localparam int unsigned  EASE_K  = 765;

  typedef struct {
    logic [15:0] x;
    logic [15:0] y;
    logic [7:0]  noise;
  } noise_exp_t;

  logic        clk_i;
  logic        rst_ni;
  logic        valid_i;
  logic        ready_o;
  logic [15:0] coord_x_i;
  logic [15:0] coord_y_i;
  logic        valid_o;
  logic        ready_i;
  logic [7:0]  noise_value_o;

  noise_exp_t  noise_q[$];
  int unsigned err_cnt;
  int unsigned cycle_cnt;
  bit          src_idle;
  bit          sink_idle;
  int unsigned sink_hold_cycles;

  value_noise_2d_8bit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (valid_i),
    .ready_o       (ready_o),
    .coord_x_i     (coord_x_i),
    .coord_y_i     (coord_y_i),
    .valid_o       (valid_o),
    .ready_i       (ready_i),
    .noise_value_o (noise_value_o)
  );

  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  // ---------------------------------------------------------------- predictor

  function automatic int ease(input logic [7:0] f);
    int unsigned ff;
    int unsigned p;
    ff = {24'd0, f};
    p  = ff * ff * (EASE_K - 2 * ff);
    return int'((p >> 16) & 32'hFF);
  endfunction

  function automatic int lattice_hash(input logic [7:0] i, input logic [7:0] j);
    logic [31:0] s;
    s = {24'd0, i} * MUL_X + {24'd0, j} * MUL_Y;
    s = s ^ (s >> 13);
    s = s * MUL_MIX;
    s = s ^ (s >> 16);
    return int'(s[7:0]);
  endfunction

  // arithmetic shift on a signed int rounds toward minus infinity
  function automatic int mix(input int a, input int b, input int w);
    return a + (((b - a) * w) >>> 8);
  endfunction

  function automatic logic [7:0] noise_at(input logic [15:0] x, input logic [15:0] y);
    logic [7:0] xi, yi, xn, yn;
    int u, v, nx0, nx1, r;
    xi  = x[15:8];
    yi  = y[15:8];
    xn  = xi + 8'd1;
    yn  = yi + 8'd1;
    u   = ease(x[7:0]);
    v   = ease(y[7:0]);
    nx0 = mix(lattice_hash(xi, yi), lattice_hash(xn, yi), u);
    nx1 = mix(lattice_hash(xi, yn), lattice_hash(xn, yn), u);
    r   = mix(nx0, nx1, v);
    return r[7:0];
  endfunction

  // ---------------------------------------------------------------- scoreboard

  // pop before push: a word cannot leave in the cycle it entered
  always @(posedge clk_i) begin
    noise_exp_t e;
    if (rst_ni) begin
      if (valid_o && ready_i) begin
        if (noise_q.size() == 0) begin
          $display("%0t: unexpected noise word, expected none, actual %0d",
                   $time, noise_value_o);
          err_cnt++;
        end else begin
          e = noise_q.pop_front();
          if (noise_value_o !== e.noise) begin
            $display("%0t: noise mismatch at x=%h y=%h, expected %0d, actual %0d",
                     $time, e.x, e.y, e.noise, noise_value_o);
            err_cnt++;
          end
        end
      end
      if (valid_i && ready_o) begin
        e.x     = coord_x_i;
        e.y     = coord_y_i;
        e.noise = noise_at(coord_x_i, coord_y_i);
        noise_q.push_back(e);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------- receiver

  initial begin
    int unsigned stall;
    ready_i = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      if (sink_hold_cycles > 0) begin
        // long hold-off so the pipeline fills and drops ready_o
        repeat (sink_hold_cycles) begin
          @(negedge clk_i);
          ready_i <= 1'b0;
        end
        sink_hold_cycles = 0;
      end
      stall = sink_idle ? $urandom_range(0, 8) : 0;
      repeat (stall) begin
        @(negedge clk_i);
        ready_i <= 1'b0;
      end
      @(negedge clk_i);
      ready_i <= 1'b1;
      do @(posedge clk_i); while (!valid_o);
    end
  end

  // ---------------------------------------------------------------- sender

  task automatic send_coord(input logic [15:0] x, input logic [15:0] y);
    int unsigned gap;
    gap = src_idle ? $urandom_range(0, 8) : 0;
    repeat (gap) begin
      @(negedge clk_i);
      valid_i <= 1'b0;
    end
    @(negedge clk_i);
    valid_i   <= 1'b1;
    coord_x_i <= x;
    coord_y_i <= y;
    do @(posedge clk_i); while (!ready_o);
  endtask

  // biased toward edge cells and edge fractions
  function automatic logic [15:0] pick_coord();
    logic [7:0] cell_idx, frac;
    cell_idx = 8'($urandom_range(0, 255));
    frac     = 8'($urandom_range(0, 255));
    case ($urandom_range(0, 5))
      0: cell_idx = 8'hFF;
      1: cell_idx = 8'h00;
      2: frac = ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
      3: frac = ($urandom_range(0, 1) != 0) ? 8'hFE : 8'h01;
      default: ;
    endcase
    return {cell_idx, frac};
  endfunction

  // ---------------------------------------------------------------- tests

  task automatic apply_reset();
    rst_ni    = 1'b0;
    valid_i   = 1'b0;
    coord_x_i = '0;
    coord_y_i = '0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
  endtask

  task automatic test_extremes();
    src_idle  = 1'b0;
    sink_idle = 1'b0;
    send_coord(16'h0000, 16'h0000);
    send_coord(16'hFFFF, 16'hFFFF);
    send_coord(16'h00FF, 16'h00FF);
    send_coord(16'hFF00, 16'hFF00);
    send_coord(16'h0000, 16'hFFFF);
    send_coord(16'hFFFF, 16'h0000);
    send_coord(16'h0080, 16'h0080);
    send_coord(16'h0001, 16'h00FE);
    send_coord(16'hAA55, 16'h55AA);
    send_coord(16'h5AA5, 16'hA55A);
    send_coord(16'h7F7F, 16'h8080);
  endtask

  // x or y cell 255 pairs with cell 0
  task automatic test_cell_wrap();
    src_idle  = 1'b1;
    sink_idle = 1'b1;
    send_coord(16'hFF80, 16'h1040);
    send_coord(16'h20C0, 16'hFF80);
    send_coord(16'hFF01, 16'hFFFE);
    send_coord(16'hFFFE, 16'hFF01);
    send_coord(16'hFF40, 16'h0040);
    send_coord(16'h0040, 16'hFF40);
    send_coord(16'hFEFF, 16'hFEFF);
    send_coord(16'h0100, 16'hFFC0);
  endtask

  task automatic test_random(input int unsigned n_items);
    int unsigned i;
    for (i = 0; i < n_items; i++) begin
      // alternate stretches with and without idling
      if (i % 100 == 0) begin
        src_idle  = $urandom_range(0, 2) != 0;
        sink_idle = $urandom_range(0, 2) != 0;
      end
      if ($urandom_range(0, 3) == 0)
        send_coord(16'($urandom_range(0, 16'hFFFF)), 16'($urandom_range(0, 16'hFFFF)));
      else
        send_coord(pick_coord(), pick_coord());
    end
  endtask

  task automatic test_backpressure();
    int unsigned i;
    src_idle         = 1'b0;
    sink_idle        = 1'b0;
    sink_hold_cycles = 80;
    for (i = 0; i < 40; i++)
      send_coord(pick_coord(), pick_coord());
    sink_idle = 1'b1;
  endtask

  initial begin
    err_cnt          = 0;
    cycle_cnt        = 0;
    src_idle         = 1'b0;
    sink_idle        = 1'b0;
    sink_hold_cycles = 0;
    apply_reset();
    test_extremes();
    test_cell_wrap();
    test_random(450);
    test_backpressure();
    test_random(450);
    @(negedge clk_i);
    valid_i <= 1'b0;
    while (noise_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (err_cnt == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/vnz_pkg.sv
rtl/core/vnz_hash.sv
rtl/core/vnz_ease.sv
rtl/core/vnz_blend.sv
rtl/core/value_noise_2d_8bit.sv
bench/tb_top.sv
